/* design/xsd_pkg.sv */
// Shared types, constants and the generator step function for the shuffle dealer.
package xsd_pkg;

    localparam logic [31:0] SEED_WORD = 32'h6d2b79f5;

    localparam int DEF_WALL_ITEMS = 136;
    localparam int DEF_COPIES     = 4;

    localparam int TILE_W   = 6;
    localparam int REMAIN_W = 8;
    localparam int WORD_W   = 32;

    localparam logic [1:0] FUNC_STIR    = 2'd0;
    localparam logic [1:0] FUNC_SHUFFLE = 2'd1;
    localparam logic [1:0] FUNC_DRAW    = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [WORD_W-1:0] mix;
    } cmd_t;

    typedef struct packed {
        logic [TILE_W-1:0]   tile;
        logic                drawn;
        logic [REMAIN_W-1:0] remaining;
        logic [WORD_W-1:0]   random_word;
    } res_t;

    // One xorshift step; a zero result falls back to the seed.
    function automatic logic [WORD_W-1:0] gen_step(input logic [WORD_W-1:0] x_in);
        logic [WORD_W-1:0] x;
        x = x_in;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return (x == '0) ? SEED_WORD : x;
    endfunction

endpackage

/* design/xorshift_shuffle_dealer.sv */
// Shuffle dealer top level: generator, wall memory and the shuffle sequencer.
//
// Each command yields one result. A stir or an unused selector goes straight to the done
// state, and a draw on a non-empty wall passes through the draw state first. A shuffle refills
// the wall, then for every swap takes one generator step, a run of the bit-serial remainder
// unit and the read of i, read of j, write of i and write of j on the single read / single
// write port of the wall memory; the remainder unit takes most of that time. The command channel stalls
// from acceptance until the result has been loaded into the output register; a result that
// waits there does not block the next command.
module xorshift_shuffle_dealer #(
    parameter int WALL_ITEMS = xsd_pkg::DEF_WALL_ITEMS,
    parameter int COPIES     = xsd_pkg::DEF_COPIES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  xsd_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output xsd_pkg::res_t res
);

    localparam int AW = $clog2(WALL_ITEMS);
    localparam int PW = $clog2(WALL_ITEMS + 1);
    localparam int CW = $clog2(COPIES + 1);
    localparam int TW = xsd_pkg::TILE_W;
    localparam int WW = xsd_pkg::WORD_W;
    localparam int BW = $clog2(WW);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_GEN   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_RDI   = 4'd4;
    localparam logic [3:0] S_RDJ   = 4'd5;
    localparam logic [3:0] S_WRI   = 4'd6;
    localparam logic [3:0] S_WRJ   = 4'd7;
    localparam logic [3:0] S_DRAW  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]    state_reg;
    logic [WW-1:0] gen_reg;
    logic [PW-1:0] pos_reg;
    logic [AW-1:0] idx_reg;
    logic [PW-1:0] fill_val_reg;
    logic [CW-1:0] copy_cnt_reg;
    logic [WW-1:0] dvd_reg;
    logic [AW-1:0] rem_reg;
    logic [BW-1:0] bit_cnt_reg;
    logic [TW-1:0] swap_reg;
    logic [TW-1:0] tile_reg;
    logic          drawn_reg;
    logic          res_valid_reg;
    xsd_pkg::res_t res_reg;

    // Wall memory: one write and one registered read per cycle
    logic [TW-1:0] wall_mem [WALL_ITEMS];
    logic [TW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [TW-1:0] wr_data;

    // Bit-serial remainder unit signals
    logic [AW:0]   divisor;
    logic [AW:0]   rem_sh;
    logic [AW:0]   rem_diff;
    logic [AW-1:0] rem_next;

    logic          cmd_take;
    logic          res_free;
    logic [WW-1:0] gen_next;
    logic [WW-1:0] mix_next;
    logic [PW-1:0] remain_full;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign gen_next = xsd_pkg::gen_step(gen_reg);
    assign mix_next = xsd_pkg::gen_step(gen_reg ^ cmd.mix);

    assign divisor  = {1'b0, idx_reg} + (AW+1)'(1);
    assign rem_sh   = {rem_reg, dvd_reg[WW-1]};
    assign rem_diff = rem_sh - divisor;
    assign rem_next = (rem_sh >= divisor) ? rem_diff[AW-1:0] : rem_sh[AW-1:0];

    assign remain_full = PW'(WALL_ITEMS) - pos_reg;

    always_comb
    begin
        rd_addr = pos_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_FILL:
            begin
                wr_en   = 1'b1;
                wr_data = fill_val_reg[TW-1:0];
            end
            S_RDI:   rd_addr = idx_reg;
            S_RDJ:   rd_addr = rem_reg;
            S_WRI:   wr_en = 1'b1;
            S_WRJ:
            begin
                wr_en   = 1'b1;
                wr_addr = rem_reg;
                wr_data = swap_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wall_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= wall_mem[rd_addr];
    end

    // Payload registers of the sequencer
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                idx_reg      <= '0;
                fill_val_reg <= '0;
                copy_cnt_reg <= '0;
                tile_reg     <= '0;
                drawn_reg    <= 1'b0;
            end
            S_FILL:
            begin
                if (idx_reg == AW'(WALL_ITEMS - 1))
                begin
                    idx_reg <= idx_reg;
                end
                else
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
                if (copy_cnt_reg == CW'(COPIES - 1))
                begin
                    copy_cnt_reg <= '0;
                    fill_val_reg <= fill_val_reg + PW'(1);
                end
                else
                begin
                    copy_cnt_reg <= copy_cnt_reg + CW'(1);
                end
            end
            S_GEN:
            begin
                dvd_reg     <= gen_next;
                rem_reg     <= '0;
                bit_cnt_reg <= '0;
            end
            S_DIV:
            begin
                dvd_reg     <= dvd_reg << 1;
                rem_reg     <= rem_next;
                bit_cnt_reg <= bit_cnt_reg + BW'(1);
            end
            S_RDJ:   swap_reg <= rd_data_reg;
            S_WRJ:   idx_reg <= idx_reg - AW'(1);
            S_DRAW:
            begin
                tile_reg  <= rd_data_reg;
                drawn_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= xsd_pkg::SEED_WORD;
            pos_reg       <= PW'(WALL_ITEMS);
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            // the done state reloads the output register itself
            if (res_valid_reg && !res_stall && state_reg != S_DONE)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        unique case (cmd.func)
                            xsd_pkg::FUNC_STIR:
                            begin
                                gen_reg   <= mix_next;
                                state_reg <= S_DONE;
                            end
                            xsd_pkg::FUNC_SHUFFLE:
                            begin
                                gen_reg   <= mix_next;
                                state_reg <= S_FILL;
                            end
                            xsd_pkg::FUNC_DRAW:
                            begin
                                // read of wall[pos] is already under way
                                state_reg <= (pos_reg < PW'(WALL_ITEMS)) ? S_DRAW : S_DONE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_FILL:
                begin
                    if (idx_reg == AW'(WALL_ITEMS - 1))
                    begin
                        state_reg <= S_GEN;
                    end
                end
                S_GEN:
                begin
                    gen_reg   <= gen_next;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (bit_cnt_reg == BW'(WW - 1))
                    begin
                        state_reg <= S_RDI;
                    end
                end
                S_RDI:   state_reg <= S_RDJ;
                S_RDJ:   state_reg <= S_WRI;
                S_WRI:   state_reg <= S_WRJ;
                S_WRJ:
                begin
                    if (idx_reg == AW'(1))
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_GEN;
                    end
                end
                S_DRAW:
                begin
                    pos_reg   <= pos_reg + PW'(1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (res_free)
                    begin
                        res_reg.tile        <= tile_reg;
                        res_reg.drawn       <= drawn_reg;
                        res_reg.remaining   <= xsd_pkg::REMAIN_W'(remain_full);
                        res_reg.random_word <= gen_reg;
                        res_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_div_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (idx_reg != '0))
        else $error("shuffle index reached zero during a swap");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, rem_reg} < divisor))
        else $error("partial remainder not below divisor");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(WALL_ITEMS))
        else $error("draw position beyond end of wall");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != '0)
        else $error("generator state is zero");

endmodule

/* bench/xorshift_shuffle_dealer_test.sv */
// Self-checking testbench for the xorshift shuffle dealer.
`timescale 1ns / 100ps

module xorshift_shuffle_dealer_test;

    localparam int WALL      = xsd_pkg::DEF_WALL_ITEMS;
    localparam int PER_VALUE = xsd_pkg::DEF_COPIES;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int IDLE_PCT            = 28;
    localparam int RANDOM_ITEMS        = 16;
    localparam int MAX_RANDOM_SHUFFLES = 2;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    xsd_pkg::cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    xsd_pkg::res_t res;

    // no idling on either side while set
    bit calm = 1'b0;

    // predicted dealer state
    logic [xsd_pkg::WORD_W-1:0] gen_word;
    logic [xsd_pkg::TILE_W-1:0] wall_tiles [WALL];
    int unsigned                deal_pos;

    xsd_pkg::res_t dealt_q [$];

    int errors        = 0;
    int results_seen  = 0;
    int shuffles_done = 0;
    int tiles_drawn   = 0;
    int empty_draws   = 0;

    xorshift_shuffle_dealer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    function automatic logic [xsd_pkg::WORD_W-1:0] xorshift_next(
        input logic [xsd_pkg::WORD_W-1:0] s);
        logic [xsd_pkg::WORD_W-1:0] v;
        v = s ^ (s << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return (v == '0) ? xsd_pkg::SEED_WORD : v;
    endfunction

    function automatic xsd_pkg::res_t predict_deal(input xsd_pkg::cmd_t c);
        xsd_pkg::res_t              r;
        int unsigned                j;
        logic [xsd_pkg::TILE_W-1:0] t;
        r = '0;
        if (c.func == xsd_pkg::FUNC_STIR || c.func == xsd_pkg::FUNC_SHUFFLE)
        begin
            gen_word = xorshift_next(gen_word ^ c.mix);
            if (c.func == xsd_pkg::FUNC_SHUFFLE)
            begin
                for (int k = 0; k < WALL; k++)
                    wall_tiles[k] = xsd_pkg::TILE_W'(k / PER_VALUE);
                // Fisher-Yates with the plain modulo, bias and all
                for (int i = WALL - 1; i > 0; i--)
                begin
                    gen_word = xorshift_next(gen_word);
                    j = gen_word % xsd_pkg::WORD_W'(i + 1);
                    t = wall_tiles[i];
                    wall_tiles[i] = wall_tiles[j];
                    wall_tiles[j] = t;
                end
                deal_pos = 0;
                shuffles_done++;
            end
        end
        else if (c.func == xsd_pkg::FUNC_DRAW)
        begin
            if (deal_pos < WALL)
            begin
                r.tile  = wall_tiles[deal_pos];
                r.drawn = 1'b1;
                deal_pos++;
                tiles_drawn++;
            end
            else
                empty_draws++;
        end
        r.remaining   = xsd_pkg::REMAIN_W'(WALL - deal_pos);
        r.random_word = gen_word;
        return r;
    endfunction

    // Send one item and queue its expected result once it is taken.
    task automatic deal_cmd(input logic [1:0] f, input logic [xsd_pkg::WORD_W-1:0] m);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{func: f, mix: m};
        do
            @(posedge clk);
        while (cmd_stall);
        dealt_q.push_back(predict_deal('{func: f, mix: m}));
    endtask

    always @(posedge clk)
    begin
        xsd_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (dealt_q.size() == 0)
            begin
                $error("unexpected result: %p", res);
                errors++;
            end
            else
            begin
                want = dealt_q.pop_front();
                results_seen++;
                if (res.tile !== want.tile)
                begin
                    $error("tile: expected %0d, got %0d", want.tile, res.tile);
                    errors++;
                end
                if (res.drawn !== want.drawn)
                begin
                    $error("drawn: expected %0b, got %0b", want.drawn, res.drawn);
                    errors++;
                end
                if (res.remaining !== want.remaining)
                begin
                    $error("remaining: expected %0d, got %0d", want.remaining, res.remaining);
                    errors++;
                end
                if (res.random_word !== want.random_word)
                begin
                    $error("random_word: expected %h, got %h",
                           want.random_word, res.random_word);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_wall();
        deal_cmd(xsd_pkg::FUNC_DRAW, '0);
        deal_cmd(xsd_pkg::FUNC_DRAW, '1);
        deal_cmd(FUNC_UNUSED, $urandom());
        deal_cmd(FUNC_UNUSED, '1);
    endtask

    task automatic test_stir();
        deal_cmd(xsd_pkg::FUNC_STIR, '0);
        deal_cmd(xsd_pkg::FUNC_STIR, '1);
        // cancel the state to zero so the generator reloads its seed
        deal_cmd(xsd_pkg::FUNC_STIR, gen_word);
        deal_cmd(xsd_pkg::FUNC_STIR, $urandom());
        deal_cmd(FUNC_UNUSED, '0);
    endtask

    task automatic test_shuffle_and_draw();
        deal_cmd(xsd_pkg::FUNC_SHUFFLE, '1);
        deal_cmd(xsd_pkg::FUNC_DRAW, '0);
        deal_cmd(xsd_pkg::FUNC_DRAW, '1);
        deal_cmd(xsd_pkg::FUNC_DRAW, $urandom());
        deal_cmd(xsd_pkg::FUNC_STIR, $urandom());
        deal_cmd(xsd_pkg::FUNC_DRAW, $urandom());
        deal_cmd(FUNC_UNUSED, $urandom());
        deal_cmd(xsd_pkg::FUNC_SHUFFLE, gen_word);
        repeat (3) deal_cmd(xsd_pkg::FUNC_DRAW, $urandom());
        deal_cmd(xsd_pkg::FUNC_SHUFFLE, '0);
        repeat (2) deal_cmd(xsd_pkg::FUNC_DRAW, $urandom());
    endtask

    // Run the whole wall out and past its end, with both sides flat out.
    task automatic test_drain_wall();
        calm <= 1'b1;
        deal_cmd(xsd_pkg::FUNC_SHUFFLE, $urandom());
        repeat (WALL + 2) deal_cmd(xsd_pkg::FUNC_DRAW, $urandom());
        calm <= 1'b0;
    endtask

    task automatic test_random_mix();
        int unsigned                pick;
        int unsigned                budget;
        logic [xsd_pkg::WORD_W-1:0] m;
        logic [1:0]                 f;
        budget = MAX_RANDOM_SHUFFLES;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(9))
                0:       m = '0;
                1:       m = '1;
                2:       m = gen_word;
                default: m = $urandom();
            endcase
            pick = $urandom_range(99);
            if (pick < 9 && budget != 0)
            begin
                f = xsd_pkg::FUNC_SHUFFLE;
                budget--;
            end
            else if (pick < 22)
                f = xsd_pkg::FUNC_STIR;
            else if (pick < 26)
                f = FUNC_UNUSED;
            else
                f = xsd_pkg::FUNC_DRAW;
            deal_cmd(f, m);
        end
    endtask

    initial
    begin
        gen_word = xsd_pkg::SEED_WORD;
        deal_pos = WALL;
        foreach (wall_tiles[k])
            wall_tiles[k] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_wall();
        test_stir();
        test_shuffle_and_draw();
        test_drain_wall();
        test_random_mix();

        cmd_valid <= 1'b0;
        while (dealt_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d results: %0d shuffles, %0d tiles dealt, %0d empty-wall draws.",
                 results_seen, shuffles_done, tiles_drawn, empty_draws);
        $display("Stirs, unused selector and zero-state seed reloads included.");
        if (errors == 0)
            $display("** xorshift_shuffle_dealer: PASSED **");
        else
            $display("** xorshift_shuffle_dealer: FAILED **");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timed out with %0d results outstanding.", dealt_q.size());
        $display("** xorshift_shuffle_dealer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
design/xsd_pkg.sv
design/xorshift_shuffle_dealer.sv
bench/xorshift_shuffle_dealer_test.sv
